@@ src/tppc_pkg.sv @@
// shared types and constants for the tcp port payload capture block
package tppc_pkg;

    localparam int unsigned MAX_CAPTURE_DEFAULT = 24576;

    localparam logic [15:0] CAPTURE_PORT_RESET = 16'd2000;
    localparam logic [15:0] ETHERTYPE_IPV4     = 16'h0800;
    localparam logic [7:0]  PROTOCOL_TCP       = 8'd6;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_COMMIT  = 2'd1;
    localparam logic [1:0] KIND_DROP    = 2'd2;
    localparam logic [1:0] KIND_ABORT   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_SOURCE_IP    = 2'd0;
    localparam logic [1:0] CFG_CAPTURE_PORT = 2'd1;
    localparam logic [1:0] CFG_SOURCE_TAG   = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
        logic       sink_full;
    } frame_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  payload_byte;
        logic [63:0] sequence_number;
        logic [14:0] payload_length;
        logic [7:0]  tag_out;
        logic [63:0] drop_total;
        logic        last_of_run;
    } result_item_t;

    typedef struct packed {
        logic [31:0] filter_source_ip;
        logic [15:0] capture_port;
        logic [7:0]  source_tag;
    } cfg_t;

    // results handed from the parser to the output queue in the same cycle
    typedef struct packed {
        logic first;
        logic second;
    } push_t;

endpackage

@@ src/tcp_port_payload_capture.sv @@
// bytes are registered in the input stage and parsed when the queue has room; results then queue
// throughput: one frame byte per cycle while the queue has room; a frame-end byte may give two
// results, which a four-entry output queue absorbs while draining one result per unstalled cycle
// reset: rst_n low clears frame state, the drop counter and the queue at once, sets the sequence
// counter to all ones and loads the register reset values; no clearing pass is needed
module tcp_port_payload_capture #(
    parameter int unsigned MAX_CAPTURE = tppc_pkg::MAX_CAPTURE_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic                   frame_valid,
    output logic                   frame_stall,
    input  tppc_pkg::frame_item_t  frame_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output tppc_pkg::result_item_t result_item
);

    tppc_pkg::cfg_t         cfg_reg;
    tppc_pkg::push_t        push;
    tppc_pkg::result_item_t first_item;
    tppc_pkg::result_item_t second_item;
    logic                   room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_source_ip <= 32'd0;
            cfg_reg.capture_port     <= tppc_pkg::CAPTURE_PORT_RESET;
            cfg_reg.source_tag       <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tppc_pkg::CFG_SOURCE_IP:    cfg_reg.filter_source_ip <= cfg_data;
                tppc_pkg::CFG_CAPTURE_PORT: cfg_reg.capture_port     <= cfg_data[15:0];
                tppc_pkg::CFG_SOURCE_TAG:   cfg_reg.source_tag       <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    tppc_parser #(
        .MAX_CAPTURE (MAX_CAPTURE)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_item  (frame_item),
        .room        (room),
        .push        (push),
        .first_item  (first_item),
        .second_item (second_item)
    );

    tppc_result_fifo u_result_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .first_item   (first_item),
        .second_item  (second_item),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    // a pair of results always ends with the status, which closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> (!first_item.last_of_run && second_item.last_of_run))
        else $error("two-result transfer pair has wrong last_of_run marks");

    // a status result is always the final result of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_item.result_kind != tppc_pkg::KIND_PAYLOAD)
        |-> result_item.last_of_run)
        else $error("status result without last_of_run");

    // input only backs up when results are waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_stall |-> result_valid)
        else $error("input stalled with an empty result queue");

    // a dropped status counts one drop above the payload byte it is paired with
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.second && second_item.result_kind == tppc_pkg::KIND_DROP)
        |-> second_item.drop_total == first_item.drop_total + 64'd1)
        else $error("drop count inconsistent");

endmodule

@@ src/tppc_parser.sv @@
// input stage, header field capture, filter decision and result forming
module tppc_parser #(
    parameter int unsigned MAX_CAPTURE = tppc_pkg::MAX_CAPTURE_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tppc_pkg::cfg_t         cfg,
    input  logic                   frame_valid,
    output logic                   frame_stall,
    input  tppc_pkg::frame_item_t  frame_item,
    input  logic                   room,
    output tppc_pkg::push_t        push,
    output tppc_pkg::result_item_t first_item,
    output tppc_pkg::result_item_t second_item
);

    localparam logic [14:0] CAP_LIMIT = 15'(MAX_CAPTURE);

    localparam logic [7:0] POS_ETYPE_HI = 8'd12;
    localparam logic [7:0] POS_ETYPE_LO = 8'd13;
    localparam logic [7:0] POS_IHL      = 8'd14;
    localparam logic [7:0] POS_TLEN_HI  = 8'd16;
    localparam logic [7:0] POS_TLEN_LO  = 8'd17;
    localparam logic [7:0] POS_PROTO    = 8'd23;
    localparam logic [7:0] POS_SRC_LO   = 8'd26;
    localparam logic [7:0] POS_SRC_HI   = 8'd29;
    localparam logic [7:0] OFF_PORT_HI  = 8'd2;
    localparam logic [7:0] OFF_PORT_LO  = 8'd3;
    localparam logic [7:0] OFF_DOFF     = 8'd12;
    localparam logic [7:0] OFF_FLAGS    = 8'd13;
    localparam logic [3:0] MIN_WORDS    = 4'd5;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_PASS
    } phase_t;

    logic                  stage_valid_reg, stage_valid_next;
    tppc_pkg::frame_item_t stage_item_reg;
    logic [7:0]            pos_reg, pos_next;
    logic [15:0]           ether_type_reg, ether_type_next;
    logic [3:0]            ihl_reg, ihl_next;
    logic [15:0]           total_len_reg, total_len_next;
    logic [7:0]            protocol_reg, protocol_next;
    logic [31:0]           src_addr_reg, src_addr_next;
    logic [15:0]           dst_port_reg, dst_port_next;
    logic [3:0]            tdw_reg, tdw_next;
    logic [2:0]            flags_reg, flags_next;
    phase_t                phase_reg, phase_next;
    logic [14:0]           cap_len_reg, cap_len_next;
    logic [14:0]           remaining_reg, remaining_next;
    logic [63:0]           seq_reg, seq_next;
    logic [63:0]           drop_reg, drop_next;

    logic        advance;
    logic        accept;
    logic [7:0]  d;
    logic [7:0]  tcp_base;
    logic [7:0]  off;
    logic [7:0]  hdr_last;
    logic [6:0]  hdr_bytes;
    logic [15:0] len_raw;
    logic [14:0] len_clamped;
    logic        len_ok;
    logic        match;
    logic        bad_len_field;
    logic        pay_emit;
    logic        stat_emit;
    logic [1:0]  stat_kind;

    tppc_pkg::result_item_t pay_item;
    tppc_pkg::result_item_t stat_item;

    assign advance     = stage_valid_reg && room;
    assign frame_stall = stage_valid_reg && !room;
    assign accept      = frame_valid && !frame_stall;
    assign d           = stage_item_reg.data_byte;

    // tcp header starts after ihl*4 bytes of ip header
    assign tcp_base  = 8'd14 + {2'b00, ihl_reg, 2'b00};
    assign off       = pos_reg - tcp_base;
    assign hdr_last  = {2'b00, tdw_reg, 2'b00} - 8'd1;
    assign hdr_bytes = {1'b0, ihl_reg, 2'b00} + {1'b0, tdw_reg, 2'b00};
    assign len_ok    = total_len_reg > {9'd0, hdr_bytes};
    assign len_raw   = total_len_reg - {9'd0, hdr_bytes};
    assign len_clamped = (len_raw > {1'b0, CAP_LIMIT}) ? CAP_LIMIT : len_raw[14:0];

    assign match = (ether_type_reg == tppc_pkg::ETHERTYPE_IPV4)
                && (protocol_reg == tppc_pkg::PROTOCOL_TCP)
                && (dst_port_reg == cfg.capture_port)
                && ((cfg.filter_source_ip == 32'd0) || (src_addr_reg == cfg.filter_source_ip))
                && (flags_reg == 3'd0)
                && len_ok;

    always_comb
    begin
        stage_valid_next = accept ? 1'b1 : (advance ? 1'b0 : stage_valid_reg);
        pos_next         = pos_reg;
        ether_type_next  = ether_type_reg;
        ihl_next         = ihl_reg;
        total_len_next   = total_len_reg;
        protocol_next    = protocol_reg;
        src_addr_next    = src_addr_reg;
        dst_port_next    = dst_port_reg;
        tdw_next         = tdw_reg;
        flags_next       = flags_reg;
        phase_next       = phase_reg;
        cap_len_next     = cap_len_reg;
        remaining_next   = remaining_reg;
        seq_next         = seq_reg;
        drop_next        = drop_reg;
        bad_len_field    = 1'b0;
        pay_emit         = 1'b0;
        stat_emit        = 1'b0;
        stat_kind        = tppc_pkg::KIND_COMMIT;

        if (advance)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg == POS_ETYPE_HI)
                        ether_type_next = {d, 8'h00};
                    else if (pos_reg == POS_ETYPE_LO)
                        ether_type_next = {ether_type_reg[15:8], d};
                    else if (pos_reg == POS_IHL)
                    begin
                        ihl_next = d[3:0];
                        if (d[3:0] < MIN_WORDS)
                        begin
                            phase_next    = PH_PASS;
                            bad_len_field = 1'b1;
                        end
                    end
                    else if (pos_reg == POS_TLEN_HI)
                        total_len_next = {d, 8'h00};
                    else if (pos_reg == POS_TLEN_LO)
                        total_len_next = {total_len_reg[15:8], d};
                    else if (pos_reg == POS_PROTO)
                        protocol_next = d;
                    else if (pos_reg >= POS_SRC_LO && pos_reg <= POS_SRC_HI)
                        src_addr_next = {src_addr_reg[23:0], d};

                    if (!bad_len_field && pos_reg >= POS_IHL && pos_reg >= tcp_base)
                    begin
                        if (off == OFF_PORT_HI)
                            dst_port_next = {d, 8'h00};
                        else if (off == OFF_PORT_LO)
                            dst_port_next = {dst_port_reg[15:8], d};
                        else if (off == OFF_DOFF)
                        begin
                            tdw_next = d[7:4];
                            if (d[7:4] < MIN_WORDS)
                            begin
                                phase_next    = PH_PASS;
                                bad_len_field = 1'b1;
                            end
                        end
                        else if (off == OFF_FLAGS)
                            flags_next = d[2:0];

                        // last tcp header byte: all fields are in, decide
                        if (!bad_len_field && off >= OFF_FLAGS && off == hdr_last)
                        begin
                            if (match)
                            begin
                                cap_len_next   = len_clamped;
                                remaining_next = len_clamped;
                                seq_next       = seq_reg + 64'd1;
                                phase_next     = PH_PAYLOAD;
                            end
                            else
                                phase_next = PH_PASS;
                        end
                    end

                    if (!bad_len_field)
                        pos_next = pos_reg + 8'd1;
                end
                PH_PAYLOAD:
                begin
                    if (remaining_reg != 15'd0)
                    begin
                        pay_emit       = 1'b1;
                        remaining_next = remaining_reg - 15'd1;
                    end
                end
                default:
                begin
                end
            endcase

            if (stage_item_reg.end_of_frame)
            begin
                if (phase_next == PH_PAYLOAD)
                begin
                    stat_emit = 1'b1;
                    if (remaining_next != 15'd0)
                        stat_kind = tppc_pkg::KIND_ABORT;
                    else if (stage_item_reg.sink_full)
                    begin
                        stat_kind = tppc_pkg::KIND_DROP;
                        drop_next = drop_reg + 64'd1;
                    end
                    else
                        stat_kind = tppc_pkg::KIND_COMMIT;
                end
                pos_next        = 8'd0;
                ether_type_next = 16'd0;
                ihl_next        = 4'd0;
                total_len_next  = 16'd0;
                protocol_next   = 8'd0;
                src_addr_next   = 32'd0;
                dst_port_next   = 16'd0;
                tdw_next        = 4'd0;
                flags_next      = 3'd0;
                phase_next      = PH_HEADER;
                cap_len_next    = 15'd0;
                remaining_next  = 15'd0;
            end
        end
    end

    always_comb
    begin
        pay_item.result_kind     = tppc_pkg::KIND_PAYLOAD;
        pay_item.payload_byte    = d;
        pay_item.sequence_number = seq_reg;
        pay_item.payload_length  = cap_len_reg;
        pay_item.tag_out         = 8'd0;
        pay_item.drop_total      = drop_reg;
        pay_item.last_of_run     = !stat_emit;

        // status sees the sequence and length set by a decision on this same byte
        stat_item.result_kind     = stat_kind;
        stat_item.payload_byte    = 8'd0;
        stat_item.sequence_number = seq_next;
        stat_item.payload_length  = (phase_reg == PH_HEADER) ? len_clamped : cap_len_reg;
        stat_item.tag_out         = cfg.source_tag;
        stat_item.drop_total      = drop_next;
        stat_item.last_of_run     = 1'b1;

        push.first  = pay_emit || stat_emit;
        push.second = pay_emit && stat_emit;
        first_item  = pay_emit ? pay_item : stat_item;
        second_item = stat_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            pos_reg         <= 8'd0;
            ether_type_reg  <= 16'd0;
            ihl_reg         <= 4'd0;
            total_len_reg   <= 16'd0;
            protocol_reg    <= 8'd0;
            src_addr_reg    <= 32'd0;
            dst_port_reg    <= 16'd0;
            tdw_reg         <= 4'd0;
            flags_reg       <= 3'd0;
            phase_reg       <= PH_HEADER;
            cap_len_reg     <= 15'd0;
            remaining_reg   <= 15'd0;
            seq_reg         <= '1;
            drop_reg        <= 64'd0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            pos_reg         <= pos_next;
            ether_type_reg  <= ether_type_next;
            ihl_reg         <= ihl_next;
            total_len_reg   <= total_len_next;
            protocol_reg    <= protocol_next;
            src_addr_reg    <= src_addr_next;
            dst_port_reg    <= dst_port_next;
            tdw_reg         <= tdw_next;
            flags_reg       <= flags_next;
            phase_reg       <= phase_next;
            cap_len_reg     <= cap_len_next;
            remaining_reg   <= remaining_next;
            seq_reg         <= seq_next;
            drop_reg        <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_item_reg <= frame_item;
    end

endmodule

@@ src/tppc_result_fifo.sv @@
// four-entry result queue taking up to two results per cycle, giving one per cycle unless stalled
module tppc_result_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tppc_pkg::push_t        push,
    input  tppc_pkg::result_item_t first_item,
    input  tppc_pkg::result_item_t second_item,
    output logic                   room,
    output logic                   result_valid,
    input  logic                   result_stall,
    output tppc_pkg::result_item_t result_item
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tppc_pkg::result_item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign result_valid = count_reg != CNT_W'(0);
    assign result_item  = mem[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;
    // room for a worst case of two results from the next byte
    assign room         = count_reg <= CNT_W'(DEPTH - 2);

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push.first) + PTR_W'(push.second);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push.first) + CNT_W'(push.second)
                       - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
            mem[wr_ptr_reg] <= first_item;
        if (push.second)
            mem[wr_ptr_reg + PTR_W'(1)] <= second_item;
    end

endmodule
